/* src/unte_pkg.sv */
// package for the udp nat translation engine
// types, constants and register indexes; no dependencies
package unte_pkg;

   localparam int MAP_DEPTH = 16;
   localparam int SESSION_DEPTH = 64;
   localparam int MAP_AW = $clog2(MAP_DEPTH);
   localparam int SESS_AW = $clog2(SESSION_DEPTH);
   localparam int MAP_CW = $clog2(MAP_DEPTH + 1);
   localparam int SESS_CW = $clog2(SESSION_DEPTH + 1);

   localparam logic [15:0] PUB_PORT_BASE = 16'd2000;
   localparam logic [15:0] PORT_STEP = 16'd100;
   localparam logic [1:0] PORTS_PER_IP = 2'd3;

   localparam logic [2:0] CSR_OUTSIDE_IP = 3'd0;
   localparam logic [2:0] CSR_OUTSIDE_MASK = 3'd1;
   localparam logic [2:0] CSR_INSIDE_IP = 3'd2;
   localparam logic [2:0] CSR_INSIDE_MASK = 3'd3;
   localparam logic [2:0] CSR_BLOCK_A_LOW = 3'd4;
   localparam logic [2:0] CSR_BLOCK_A_HIGH = 3'd5;
   localparam logic [2:0] CSR_BLOCK_B_LOW = 3'd6;
   localparam logic [2:0] CSR_BLOCK_B_HIGH = 3'd7;

   localparam logic [2:0] VERDICT_FORWARD = 3'd0;
   localparam logic [2:0] VERDICT_NO_MAP = 3'd1;
   localparam logic [2:0] VERDICT_NO_SESSION = 3'd2;
   localparam logic [2:0] VERDICT_BLOCKED = 3'd3;
   localparam logic [2:0] VERDICT_FULL = 3'd4;

   typedef struct packed {
      logic        from_outside;
      logic [31:0] src_ip;
      logic [15:0] sport;
      logic [31:0] dst_ip;
      logic [15:0] dport;
   } req_type;

   typedef struct packed {
      logic [31:0] new_src_ip;
      logic [15:0] new_src_port;
      logic [31:0] new_dst_ip;
      logic [15:0] new_dst_port;
      logic        egress_iface;
      logic [2:0]  verdict;
   } rsp_type;

   typedef struct packed {
      logic [31:0] outside_ip;
      logic [31:0] outside_mask;
      logic [31:0] inside_ip;
      logic [31:0] inside_mask;
      logic [15:0] block_a_low;
      logic [15:0] block_a_high;
      logic [15:0] block_b_low;
      logic [15:0] block_b_high;
   } csr_type;

   // controller to datapath
   typedef struct packed {
      logic load;          // capture request
      logic map_start;     // reset map scan index
      logic map_step;      // advance map scan
      logic map_pub;       // map scan compares public side
      logic sess_start;
      logic sess_step;
      logic sess_setup;    // choose session key from map result
      logic commit;        // write tables and build response
      logic finish_drop;   // build response for a drop
      logic [2:0] drop_verdict;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic outside;
      logic blocked;
      logic map_done;
      logic map_hit;
      logic sess_done;
      logic sess_hit;
      logic map_full;
      logic sess_full;
   } stat_type;

endpackage

/* src/unte_datapath.sv */
// datapath of the udp nat translation engine: tables, scan counters, rewrite
// depends on unte_pkg
module unte_datapath (
   input  logic              clock,
   input  logic              reset,
   input  unte_pkg::csr_type csr,
   input  unte_pkg::req_type req,
   input  unte_pkg::cmd_type cmd,
   output unte_pkg::stat_type stat,
   output unte_pkg::rsp_type rsp
);
   localparam int MAW = unte_pkg::MAP_AW;
   localparam int SAW = unte_pkg::SESS_AW;
   localparam int MCW = unte_pkg::MAP_CW;
   localparam int SCW = unte_pkg::SESS_CW;

   logic [95:0] map_mem [unte_pkg::MAP_DEPTH];
   logic [95:0] sess_mem [unte_pkg::SESSION_DEPTH];

   unte_pkg::req_type req_ff;
   logic [MCW-1:0] map_count_ff, map_idx_ff, map_idx_in;
   logic [SCW-1:0] sess_count_ff, sess_idx_ff, sess_idx_in;
   logic [95:0] map_rd_ff, sess_rd_ff;
   logic map_rd_vld_ff, sess_rd_vld_ff;
   logic map_pub_ff, map_hit_ff, map_done_ff, sess_hit_ff, sess_done_ff;
   logic [95:0] map_entry_ff;
   logic [31:0] pub_ip_ff;
   logic [15:0] pub_port_ff;
   logic [MCW-1:0] quot_ff;
   logic [1:0] rem_ff;
   unte_pkg::rsp_type rsp_ff;

   logic [31:0] key_ip;
   logic [15:0] key_port;
   logic map_match, sess_match;
   logic [31:0] far_ip;
   logic [15:0] far_port;

   // map entry: loc_ip, loc_port, pub_ip, pub_port
   always_comb begin
      key_ip = map_pub_ff ? req_ff.dst_ip : req_ff.src_ip;
      key_port = map_pub_ff ? req_ff.dport : req_ff.sport;
      map_match = map_pub_ff ? (map_rd_ff[47:0] == {key_ip, key_port})
                             : (map_rd_ff[95:48] == {key_ip, key_port});
      far_ip = req_ff.from_outside ? req_ff.src_ip : req_ff.dst_ip;
      far_port = req_ff.from_outside ? req_ff.sport : req_ff.dport;
      sess_match = sess_rd_ff == {pub_ip_ff, pub_port_ff, far_ip, far_port};
      map_idx_in = map_idx_ff + MCW'(1);
      sess_idx_in = sess_idx_ff + SCW'(1);
   end

   function automatic logic iface(input unte_pkg::csr_type c, input logic [31:0] a);
      logic r;
      r = 1'b0;
      if ((c.outside_ip & c.outside_mask) != (a & c.outside_mask) &&
          (c.inside_ip & c.inside_mask) == (a & c.inside_mask))
         r = 1'b1;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req;
      if (cmd.map_start) begin
         map_idx_ff <= '0;
         map_pub_ff <= cmd.map_pub;
         map_hit_ff <= 1'b0;
         map_done_ff <= 1'b0;
         map_rd_vld_ff <= 1'b0;
      end else if (cmd.map_step) begin
         if (map_rd_vld_ff && map_match) begin
            map_hit_ff <= 1'b1;
            map_done_ff <= 1'b1;
            map_entry_ff <= map_rd_ff;
         end else if (map_idx_ff >= map_count_ff) begin
            map_done_ff <= 1'b1;
         end
         if (!map_done_ff && map_idx_ff < map_count_ff) begin
            map_rd_ff <= map_mem[map_idx_ff[MAW-1:0]];
            map_idx_ff <= map_idx_in;
            map_rd_vld_ff <= 1'b1;
         end else begin
            map_rd_vld_ff <= 1'b0;
         end
      end
      if (cmd.sess_setup) begin
         if (map_hit_ff) begin
            pub_ip_ff <= map_entry_ff[47:16];
            pub_port_ff <= map_entry_ff[15:0];
         end else begin
            pub_ip_ff <= csr.outside_ip + 32'(quot_ff) + 32'd1;
            pub_port_ff <= unte_pkg::PUB_PORT_BASE + 16'(rem_ff) * unte_pkg::PORT_STEP;
         end
      end
      if (cmd.sess_start) begin
         sess_idx_ff <= '0;
         sess_hit_ff <= 1'b0;
         sess_done_ff <= 1'b0;
         sess_rd_vld_ff <= 1'b0;
      end else if (cmd.sess_step) begin
         if (sess_rd_vld_ff && sess_match) begin
            sess_hit_ff <= 1'b1;
            sess_done_ff <= 1'b1;
         end else if (sess_idx_ff >= sess_count_ff && !sess_rd_vld_ff) begin
            sess_done_ff <= 1'b1;
         end
         if (!sess_done_ff && sess_idx_ff < sess_count_ff) begin
            sess_rd_ff <= sess_mem[sess_idx_ff[SAW-1:0]];
            sess_idx_ff <= sess_idx_in;
            sess_rd_vld_ff <= 1'b1;
         end else begin
            sess_rd_vld_ff <= 1'b0;
         end
      end
      if (cmd.finish_drop) begin
         rsp_ff <= {req_ff.src_ip, req_ff.sport, req_ff.dst_ip, req_ff.dport,
                    1'b0, cmd.drop_verdict};
      end else if (cmd.commit) begin
         if (req_ff.from_outside) begin
            rsp_ff <= {req_ff.src_ip, req_ff.sport, map_entry_ff[95:64],
                       map_entry_ff[63:48], iface(csr, map_entry_ff[95:64]),
                       unte_pkg::VERDICT_FORWARD};
         end else begin
            rsp_ff <= {pub_ip_ff, pub_port_ff, req_ff.dst_ip, req_ff.dport,
                       iface(csr, req_ff.dst_ip), unte_pkg::VERDICT_FORWARD};
            if (!map_hit_ff)
               map_mem[map_count_ff[MAW-1:0]] <= {req_ff.src_ip, req_ff.sport,
                                                 pub_ip_ff, pub_port_ff};
            if (!sess_hit_ff)
               sess_mem[sess_count_ff[SAW-1:0]] <= {pub_ip_ff, pub_port_ff,
                                                   req_ff.dst_ip, req_ff.dport};
         end
      end
   end

   // counts and count/3 kept incrementally
   always_ff @(posedge clock) begin
      if (reset) begin
         map_count_ff <= '0;
         sess_count_ff <= '0;
         quot_ff <= '0;
         rem_ff <= '0;
      end else if (cmd.commit && !req_ff.from_outside) begin
         if (!map_hit_ff) begin
            map_count_ff <= map_count_ff + MCW'(1);
            if (rem_ff == unte_pkg::PORTS_PER_IP - 2'd1) begin
               rem_ff <= '0;
               quot_ff <= quot_ff + MCW'(1);
            end else begin
               rem_ff <= rem_ff + 2'd1;
            end
         end
         if (!sess_hit_ff) sess_count_ff <= sess_count_ff + SCW'(1);
      end
   end

   always_comb begin
      stat.outside = req_ff.from_outside;
      stat.blocked = (req_ff.sport >= csr.block_a_low && req_ff.sport <= csr.block_a_high) ||
                     (req_ff.sport >= csr.block_b_low && req_ff.sport <= csr.block_b_high);
      stat.map_done = map_done_ff;
      stat.map_hit = map_hit_ff;
      stat.sess_done = sess_done_ff;
      stat.sess_hit = sess_hit_ff;
      stat.map_full = map_count_ff == MCW'(unte_pkg::MAP_DEPTH);
      stat.sess_full = sess_count_ff == SCW'(unte_pkg::SESSION_DEPTH);
      rsp = rsp_ff;
   end
endmodule

/* src/unte_control.sv */
// controller of the udp nat translation engine: sequences scans and response
// depends on unte_pkg
module unte_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  unte_pkg::stat_type stat,
   output unte_pkg::cmd_type  cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MAP = 3'd2;
   localparam logic [2:0] ST_SETUP = 3'd3;
   localparam logic [2:0] ST_SESS = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;

   logic [2:0] state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic busy;
   logic rsp_free;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      busy = state_ff != ST_IDLE;
      rsp_free = !rsp_valid_ff || rsp_ready;
      req_ready = !busy;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat.outside && stat.blocked) begin
               if (rsp_free) begin
                  cmd.finish_drop = 1'b1;
                  cmd.drop_verdict = unte_pkg::VERDICT_BLOCKED;
                  rsp_valid_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.map_start = 1'b1;
               cmd.map_pub = stat.outside;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map_step = 1'b1;
            if (stat.map_done) begin
               cmd.map_step = 1'b0;
               if (stat.outside && !stat.map_hit) begin
                  if (rsp_free) begin
                     cmd.finish_drop = 1'b1;
                     cmd.drop_verdict = unte_pkg::VERDICT_NO_MAP;
                     rsp_valid_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  cmd.sess_setup = 1'b1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.sess_start = 1'b1;
            state_in = ST_SESS;
         end
         ST_SESS: begin
            cmd.sess_step = 1'b1;
            if (stat.sess_done) begin
               cmd.sess_step = 1'b0;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
               if (stat.outside) begin
                  if (stat.sess_hit) cmd.commit = 1'b1;
                  else begin
                     cmd.finish_drop = 1'b1;
                     cmd.drop_verdict = unte_pkg::VERDICT_NO_SESSION;
                  end
               end else if ((!stat.map_hit && stat.map_full) ||
                            (!stat.sess_hit && stat.sess_full)) begin
                  cmd.finish_drop = 1'b1;
                  cmd.drop_verdict = unte_pkg::VERDICT_FULL;
               end else begin
                  cmd.commit = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* src/udp_nat_translation_engine.sv */
// top level of the udp nat translation engine: csr bank, controller, datapath
// depends on unte_pkg, unte_control, unte_datapath
// One request at a time: for an outbound request that misses, the mapping
// table and the session table are each scanned linearly through a single
// read port, so the time from acceptance to the next acceptance grows with
// the number of stored mappings and sessions; the tables hold up to 16
// mappings and 64 sessions. A hit ends its scan early, and blocked ports and
// inbound requests without a mapping skip the later scans. The response
// is held in an output register until taken; the next request is accepted
// while it waits, but its own response is not built until the register is
// free. Table full, blocked ports and lookup misses return a verdict with the
// tuple unchanged.
module udp_nat_translation_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  unte_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output unte_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   unte_pkg::csr_type csr_ff;
   unte_pkg::cmd_type cmd;
   unte_pkg::stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= {128'd0, 16'd1, 16'd0, 16'd1, 16'd0};
      end else if (csr_write) begin
         unique case (csr_index)
            unte_pkg::CSR_OUTSIDE_IP: csr_ff.outside_ip <= csr_wdata;
            unte_pkg::CSR_OUTSIDE_MASK: csr_ff.outside_mask <= csr_wdata;
            unte_pkg::CSR_INSIDE_IP: csr_ff.inside_ip <= csr_wdata;
            unte_pkg::CSR_INSIDE_MASK: csr_ff.inside_mask <= csr_wdata;
            unte_pkg::CSR_BLOCK_A_LOW: csr_ff.block_a_low <= csr_wdata[15:0];
            unte_pkg::CSR_BLOCK_A_HIGH: csr_ff.block_a_high <= csr_wdata[15:0];
            unte_pkg::CSR_BLOCK_B_LOW: csr_ff.block_b_low <= csr_wdata[15:0];
            unte_pkg::CSR_BLOCK_B_HIGH: csr_ff.block_b_high <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   unte_control u_ctl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .stat(stat), .cmd(cmd)
   );

   unte_datapath u_dp (
      .clock(clock), .reset(reset), .csr(csr_ff), .req(req_data),
      .cmd(cmd), .stat(stat), .rsp(rsp_data)
   );

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while busy");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.finish_drop))
      else $error("commit and drop together");
endmodule

/* sim/tb_udp_nat_translation_engine.sv */
// testbench for udp_nat_translation_engine: random and directed udp tuples,
// translation predicted in a scoreboard class and checked per response
// depends on unte_pkg and the engine rtl
`timescale 1ns / 1ps

class nat_scoreboard;
   unte_pkg::csr_type cfg;
   logic [31:0] map_loc_ip[unte_pkg::MAP_DEPTH];
   logic [15:0] map_loc_port[unte_pkg::MAP_DEPTH];
   logic [31:0] map_pub_ip[unte_pkg::MAP_DEPTH];
   logic [15:0] map_pub_port[unte_pkg::MAP_DEPTH];
   logic [31:0] sess_pub_ip[unte_pkg::SESSION_DEPTH];
   logic [15:0] sess_pub_port[unte_pkg::SESSION_DEPTH];
   logic [31:0] sess_far_ip[unte_pkg::SESSION_DEPTH];
   logic [15:0] sess_far_port[unte_pkg::SESSION_DEPTH];
   int map_count;
   int sess_count;
   unte_pkg::rsp_type pending[$];
   int errors;
   int checked;
   int verdict_seen[8];

   function void clear();
      cfg = '0;
      cfg.block_a_low = 16'd1;
      cfg.block_b_low = 16'd1;
      map_count = 0;
      sess_count = 0;
      errors = 0;
      checked = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
         unte_pkg::CSR_OUTSIDE_IP:   cfg.outside_ip = val;
         unte_pkg::CSR_OUTSIDE_MASK: cfg.outside_mask = val;
         unte_pkg::CSR_INSIDE_IP:    cfg.inside_ip = val;
         unte_pkg::CSR_INSIDE_MASK:  cfg.inside_mask = val;
         unte_pkg::CSR_BLOCK_A_LOW:  cfg.block_a_low = val[15:0];
         unte_pkg::CSR_BLOCK_A_HIGH: cfg.block_a_high = val[15:0];
         unte_pkg::CSR_BLOCK_B_LOW:  cfg.block_b_low = val[15:0];
         default:                    cfg.block_b_high = val[15:0];
      endcase
   endfunction

   function int find_local(logic [31:0] ip, logic [15:0] port);
      for (int i = 0; i < map_count; i++)
         if (map_loc_ip[i] == ip && map_loc_port[i] == port) return i;
      return -1;
   endfunction

   function int find_public(logic [31:0] ip, logic [15:0] port);
      for (int i = 0; i < map_count; i++)
         if (map_pub_ip[i] == ip && map_pub_port[i] == port) return i;
      return -1;
   endfunction

   function bit has_session(logic [31:0] pip, logic [15:0] pport,
                            logic [31:0] fip, logic [15:0] fport);
      for (int i = 0; i < sess_count; i++)
         if (sess_pub_ip[i] == pip && sess_pub_port[i] == pport &&
             sess_far_ip[i] == fip && sess_far_port[i] == fport) return 1;
      return 0;
   endfunction

   function logic egress_for(logic [31:0] addr);
      if ((cfg.outside_ip & cfg.outside_mask) == (addr & cfg.outside_mask)) return 1'b0;
      if ((cfg.inside_ip & cfg.inside_mask) == (addr & cfg.inside_mask)) return 1'b1;
      return 1'b0;
   endfunction

   function bit port_blocked(logic [15:0] p);
      return (p >= cfg.block_a_low && p <= cfg.block_a_high) ||
             (p >= cfg.block_b_low && p <= cfg.block_b_high);
   endfunction

   function unte_pkg::rsp_type translate(unte_pkg::req_type r);
      unte_pkg::rsp_type o;
      int mi;
      logic [31:0] pip;
      logic [15:0] pport;
      bit new_map;
      bit new_sess;
      o.new_src_ip = r.src_ip;
      o.new_src_port = r.sport;
      o.new_dst_ip = r.dst_ip;
      o.new_dst_port = r.dport;
      o.egress_iface = 1'b0;
      o.verdict = unte_pkg::VERDICT_FORWARD;
      new_map = 0;
      if (r.from_outside) begin
         mi = find_public(r.dst_ip, r.dport);
         if (mi < 0) begin
            o.verdict = unte_pkg::VERDICT_NO_MAP;
         end else if (!has_session(r.dst_ip, r.dport, r.src_ip, r.sport)) begin
            o.verdict = unte_pkg::VERDICT_NO_SESSION;
         end else begin
            o.new_dst_ip = map_loc_ip[mi];
            o.new_dst_port = map_loc_port[mi];
            o.egress_iface = egress_for(map_loc_ip[mi]);
         end
      end else if (port_blocked(r.sport)) begin
         o.verdict = unte_pkg::VERDICT_BLOCKED;
      end else begin
         mi = find_local(r.src_ip, r.sport);
         if (mi >= 0) begin
            pip = map_pub_ip[mi];
            pport = map_pub_port[mi];
         end else begin
            pip = cfg.outside_ip + 32'(map_count / 3) + 32'd1;
            pport = unte_pkg::PUB_PORT_BASE + 16'((map_count % 3) * 100);
            new_map = 1;
         end
         new_sess = !has_session(pip, pport, r.dst_ip, r.dport);
         if ((new_map && map_count >= unte_pkg::MAP_DEPTH) ||
             (new_sess && sess_count >= unte_pkg::SESSION_DEPTH)) begin
            o.verdict = unte_pkg::VERDICT_FULL;
         end else begin
            if (new_map) begin
               map_loc_ip[map_count] = r.src_ip;
               map_loc_port[map_count] = r.sport;
               map_pub_ip[map_count] = pip;
               map_pub_port[map_count] = pport;
               map_count++;
            end
            if (new_sess) begin
               sess_pub_ip[sess_count] = pip;
               sess_pub_port[sess_count] = pport;
               sess_far_ip[sess_count] = r.dst_ip;
               sess_far_port[sess_count] = r.dport;
               sess_count++;
            end
            o.new_src_ip = pip;
            o.new_src_port = pport;
            o.egress_iface = egress_for(r.dst_ip);
         end
      end
      return o;
   endfunction

   function void note_request(unte_pkg::req_type r);
      pending.insert(pending.size(), translate(r));
   endfunction

   function void check_response(unte_pkg::rsp_type a);
      unte_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected response %h", a);
         errors++;
         return;
      end
      e = pending.pop_front();
      checked++;
      verdict_seen[e.verdict]++;
      if (a.new_src_ip !== e.new_src_ip) begin
         $error("new_src_ip expected %h actual %h", e.new_src_ip, a.new_src_ip);
         errors++;
      end
      if (a.new_src_port !== e.new_src_port) begin
         $error("new_src_port expected %h actual %h", e.new_src_port, a.new_src_port);
         errors++;
      end
      if (a.new_dst_ip !== e.new_dst_ip) begin
         $error("new_dst_ip expected %h actual %h", e.new_dst_ip, a.new_dst_ip);
         errors++;
      end
      if (a.new_dst_port !== e.new_dst_port) begin
         $error("new_dst_port expected %h actual %h", e.new_dst_port, a.new_dst_port);
         errors++;
      end
      if (a.egress_iface !== e.egress_iface) begin
         $error("egress_iface expected %h actual %h", e.egress_iface, a.egress_iface);
         errors++;
      end
      if (a.verdict !== e.verdict) begin
         $error("verdict expected %h actual %h", e.verdict, a.verdict);
         errors++;
      end
   endfunction
endclass

module tb_udp_nat_translation_engine;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   unte_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   unte_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = unte_pkg::CSR_OUTSIDE_IP;
   logic [31:0] csr_wdata = '0;

   nat_scoreboard sb = new();
   int send_idle = 0;
   int recv_idle = 0;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_left = 0;
   int cycles = 0;
   logic [31:0] host_ip[24];
   logic [15:0] host_port[24];
   logic [31:0] peer_ip[6];
   logic [15:0] peer_port[6];

   udp_nat_translation_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         if (hold_left == 0) hold_left = HOLD_CYCLES;
         hold_left = hold_left - 1;
         if (hold_left == 0) hold_done = 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic send_request(unte_pkg::req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_regs(logic [31:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_write <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         sb.write_reg(3'(i), vals[i]);
         @(negedge clock);
      end
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   function automatic unte_pkg::req_type make_request();
      unte_pkg::req_type r;
      int k;
      int m;
      k = $urandom_range(99);
      r.from_outside = 1'($urandom);
      r.src_ip = $urandom;
      r.sport = 16'($urandom);
      r.dst_ip = $urandom;
      r.dport = 16'($urandom);
      if (k < 55) begin
         m = $urandom_range(23);
         r.from_outside = 1'b0;
         r.src_ip = host_ip[m];
         r.sport = host_port[m];
         m = $urandom_range(5);
         r.dst_ip = peer_ip[m];
         r.dport = peer_port[m];
      end else if (k < 88 && sb.map_count > 0) begin
         m = $urandom_range(sb.map_count - 1);
         r.from_outside = 1'b1;
         r.dst_ip = sb.map_pub_ip[m];
         r.dport = sb.map_pub_port[m];
         if ($urandom_range(9) < 8) begin
            m = $urandom_range(5);
            r.src_ip = peer_ip[m];
            r.sport = peer_port[m];
         end
      end
      return r;
   endfunction

   function automatic unte_pkg::req_type tuple(logic o, logic [31:0] sip, logic [15:0] sp,
                                               logic [31:0] dip, logic [15:0] dp);
      unte_pkg::req_type r;
      r.from_outside = o;
      r.src_ip = sip;
      r.sport = sp;
      r.dst_ip = dip;
      r.dport = dp;
      return r;
   endfunction

   initial begin
      logic [31:0] regs[8];
      sb.clear();
      for (int i = 0; i < 24; i++) begin
         host_ip[i] = {16'h0a00, 16'($urandom)};
         host_port[i] = 16'($urandom);
      end
      host_port[0] = 16'd0;
      host_port[1] = 16'hffff;
      host_port[2] = 16'd1500;
      host_port[3] = 16'd62000;
      for (int i = 0; i < 6; i++) begin
         peer_ip[i] = $urandom;
         peer_port[i] = 16'($urandom);
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: empty block ranges, zero masks
      send_request(tuple(1'b0, 32'h0, 16'h0, 32'h0, 16'h0));
      send_request(tuple(1'b0, 32'hffffffff, 16'hffff, 32'hffffffff, 16'hffff));
      send_request(tuple(1'b0, 32'h0, 16'h0, 32'h0, 16'h0));
      send_request(tuple(1'b1, 32'h0, 16'h0, 32'h1, 16'd2000));
      send_request(tuple(1'b1, 32'h5, 16'h6, 32'h1, 16'd2000));
      send_request(tuple(1'b1, 32'h0, 16'h0, 32'h7, 16'd2000));
      send_request(tuple(1'b1, 32'hffffffff, 16'hffff, 32'h1, 16'd2100));
      drain();

      regs = '{32'hffffffff, 32'hffffffff, 32'h0a000000, 32'hff000000,
               32'h0, 32'h0, 32'hffff, 32'hffff};
      write_regs(regs);
      send_request(tuple(1'b0, 32'h0a000001, 16'h0, 32'h1, 16'h1));
      send_request(tuple(1'b0, 32'h0a000001, 16'hffff, 32'h1, 16'h1));
      send_request(tuple(1'b0, 32'h0a000001, 16'h1, 32'h0a0000ff, 16'h35));
      send_request(tuple(1'b0, 32'h0a000002, 16'h2, 32'hffffffff, 16'h35));
      send_request(tuple(1'b0, 32'h0a000003, 16'h3, 32'hffffffff, 16'h35));
      send_request(tuple(1'b1, 32'h0a0000ff, 16'h35, 32'h0, 16'd2000));
      send_request(tuple(1'b1, 32'hffffffff, 16'h35, 32'h0, 16'd2100));
      send_request(tuple(1'b1, 32'h12345678, 16'h35, 32'h0, 16'd2100));
      send_request(tuple(1'b1, 32'hffffffff, 16'h35, 32'h0, 16'd2300));

      send_idle = 10;
      recv_idle = 53;
      for (int i = 0; i < 250; i++) send_request(make_request());
      drain();

      // new base: public addresses may repeat earlier ones
      regs = '{32'h0, 32'hffffff00, 32'h0a000000, 32'hffff0000,
               32'd1000, 32'd1999, 32'd5, 32'd4};
      write_regs(regs);
      send_idle = 53;
      recv_idle = 10;
      for (int i = 0; i < 250; i++) send_request(make_request());
      drain();

      regs = '{32'hc0a80100, 32'h0, 32'h0, 32'h0,
               32'd1, 32'd0, 32'd60000, 32'hffff};
      write_regs(regs);
      send_idle = 0;
      recv_idle = 0;
      hold_go = 1;
      for (int i = 0; i < 300; i++) begin
         if (i == 150) begin
            req_valid <= 1'b0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         send_request(make_request());
      end
      drain();

      $display("checked %0d responses: %0d forwarded, %0d no mapping, %0d no session,",
               sb.checked, sb.verdict_seen[unte_pkg::VERDICT_FORWARD],
               sb.verdict_seen[unte_pkg::VERDICT_NO_MAP],
               sb.verdict_seen[unte_pkg::VERDICT_NO_SESSION]);
      $display("%0d blocked, %0d table full; %0d mappings, %0d sessions stored",
               sb.verdict_seen[unte_pkg::VERDICT_BLOCKED],
               sb.verdict_seen[unte_pkg::VERDICT_FULL],
               sb.map_count, sb.sess_count);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
